>>> hdl/bdrgba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrgba_pkg
// shared widths, types and lane arithmetic for the 2x2 rgba box downscaler
// ----------------------------------------------------------------------------
package bdrgba_pkg;

  localparam int PIXEL_W        = 32;
  localparam int LANES          = 4;
  localparam int LANE_W         = 8;
  localparam int SUM_LANE_W     = 9;
  localparam int SUM_W          = LANES * SUM_LANE_W;
  localparam int CFG_W          = 10;
  localparam int MAX_OUT_SIZE   = 512;
  localparam int RESET_OUT_SIZE = 256;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [SUM_W-1:0]   lane_sum_t;

  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic row_end;
    logic frame_end;
  } scan_info_t;

  function automatic lane_sum_t widen(input pixel_t px);
    lane_sum_t r;
    r = '0;
    for (int k = 0; k < LANES; k++) begin
      r[k*SUM_LANE_W +: SUM_LANE_W] = {1'b0, px[k*LANE_W +: LANE_W]};
    end
    return r;
  endfunction

  function automatic pixel_t lane_avg(input lane_sum_t above, input lane_sum_t below);
    pixel_t                r;
    logic [SUM_LANE_W:0]   s;
    r = '0;
    for (int k = 0; k < LANES; k++) begin
      s = {1'b0, above[k*SUM_LANE_W +: SUM_LANE_W]}
        + {1'b0, below[k*SUM_LANE_W +: SUM_LANE_W]};
      r[k*LANE_W +: LANE_W] = s[SUM_LANE_W:2];
    end
    return r;
  endfunction

endpackage

>>> hdl/bdrgba_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrgba_scan
// source position counters, size register and horizontal pair sum
// ----------------------------------------------------------------------------
module bdrgba_scan #(
  parameter int MAX_OUT_SIZE = bdrgba_pkg::MAX_OUT_SIZE,
  parameter int IW           = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [bdrgba_pkg::CFG_W-1:0] cfg_write_data,
  input  logic                        advance,
  input  bdrgba_pkg::pixel_t          src_pixel,
  output bdrgba_pkg::lane_sum_t       pair,
  output logic [IW-1:0]               idx,
  output bdrgba_pkg::scan_info_t      info
);

  localparam int CW = IW + 1;
  localparam int RESET_EFF = (bdrgba_pkg::RESET_OUT_SIZE > MAX_OUT_SIZE) ?
                             MAX_OUT_SIZE : bdrgba_pkg::RESET_OUT_SIZE;
  localparam logic [IW-1:0] RESET_M1 = IW'(RESET_EFF - 1);
  localparam logic [IW-1:0] MAX_M1   = IW'(MAX_OUT_SIZE - 1);

  logic [IW-1:0]         size_m1;
  logic [IW-1:0]         size_m1_next;
  logic [CW-1:0]         col;
  logic [CW-1:0]         row;
  bdrgba_pkg::lane_sum_t pair_sum;
  bdrgba_pkg::lane_sum_t wide;
  logic                  last_col;
  logic                  last_row;

  always_comb begin
    priority if (cfg_write_data == '0) begin
      size_m1_next = '0;
    end else if (32'(cfg_write_data) > 32'(MAX_OUT_SIZE)) begin
      size_m1_next = MAX_M1;
    end else begin
      size_m1_next = IW'(32'(cfg_write_data) - 32'd1);
    end
  end

  assign wide     = bdrgba_pkg::widen(src_pixel);
  assign pair     = pair_sum + wide;
  assign idx      = col[CW-1:1];
  assign last_col = (col == {size_m1, 1'b1});
  assign last_row = (row == {size_m1, 1'b1});

  assign info.odd_col   = col[0];
  assign info.odd_row   = row[0];
  assign info.row_end   = (idx == size_m1);
  assign info.frame_end = (idx == size_m1) && (row[CW-1:1] == size_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_m1  <= RESET_M1;
      col      <= '0;
      row      <= '0;
      pair_sum <= '0;
    end else if (cfg_write_en) begin
      size_m1  <= size_m1_next;
      col      <= '0;
      row      <= '0;
      pair_sum <= '0;
    end else if (advance) begin
      if (!col[0]) begin
        pair_sum <= wide;
      end
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + CW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

endmodule

>>> hdl/bdrgba_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdrgba_line_store
// per output column pair sums of the even source row, registered read
// ----------------------------------------------------------------------------
module bdrgba_line_store #(
  parameter int DEPTH = bdrgba_pkg::MAX_OUT_SIZE,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  bdrgba_pkg::lane_sum_t wr_data,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  output bdrgba_pkg::lane_sum_t rd_data
);

  bdrgba_pkg::lane_sum_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/box_downscale_2x2_rgba_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_2x2_rgba_unit
// 2x2 box filter mipmap step for a raster stream of 32-bit rgba pixels
// ----------------------------------------------------------------------------
// Takes one source pixel per clock unless in_stall is high, from a square
// image of side 2*out_size; emits one averaged pixel per 2x2 block, flagged
// with row_end and frame_end. One write and one read port on the line store
// hold one source beat per unstalled cycle; a result passes the block sum
// stage, then the result register. Writing out_size restarts the frame;
// it is to be done by the user only while idle, unchecked by the unit.
// Zero acts as 1, above MAX_OUT_SIZE clamps; line store needs no reset clear.
module box_downscale_2x2_rgba_unit #(
  parameter int MAX_OUT_SIZE = bdrgba_pkg::MAX_OUT_SIZE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [bdrgba_pkg::CFG_W-1:0] cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [31:0]                  src_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  avg_pixel,
  output logic                         row_end,
  output logic                         frame_end
);

  localparam int IW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;

  bdrgba_pkg::lane_sum_t  pair;
  bdrgba_pkg::lane_sum_t  above;
  bdrgba_pkg::scan_info_t info;
  logic [IW-1:0]          idx;
  logic                   accept;
  logic                   produce;
  logic                   out_ready;
  logic                   s1_ready;
  logic                   s1_valid;
  bdrgba_pkg::lane_sum_t  s1_pair;
  logic                   s1_row_end;
  logic                   s1_frame_end;

  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;
  assign accept    = in_valid && s1_ready;
  assign produce   = info.odd_col && info.odd_row;

  bdrgba_scan #(
    .MAX_OUT_SIZE(MAX_OUT_SIZE),
    .IW          (IW)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .advance       (accept),
    .src_pixel     (src_pixel),
    .pair          (pair),
    .idx           (idx),
    .info          (info)
  );

  bdrgba_line_store #(
    .DEPTH(MAX_OUT_SIZE),
    .IW   (IW)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (accept && info.odd_col && !info.odd_row),
    .wr_addr(idx),
    .wr_data(pair),
    .rd_en  (accept && produce),
    .rd_addr(idx),
    .rd_data(above)
  );

  // block sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      s1_pair      <= pair;
      s1_row_end   <= info.row_end;
      s1_frame_end <= info.frame_end;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      avg_pixel <= bdrgba_pkg::lane_avg(above, s1_pair);
      row_end   <= s1_row_end;
      frame_end <= s1_frame_end;
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_end || row_end))
    else $error("frame_end beat without row_end");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_ready) |=> (s1_valid && $stable(s1_pair)))
    else $error("block sum stage lost a beat under stall");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> (idx == '0 && !info.odd_col && !info.odd_row))
    else $error("size write did not restart the frame");
`endif

endmodule
